// ----- rtl/cpec_pkg.sv -----
`default_nettype none
package cpec_pkg;

   // pipeline geometry
   localparam int SQ_N  = 32;   // result bits of the square root, one stage each
   localparam int DVD_W = 64;   // divider dividend width
   localparam int DVS_W = 33;   // divider divisor width
   localparam int QUO_W = 34;   // divider quotient width, one stage per bit

   localparam logic signed [35:0] SAT_HI = 36'sd2147483647;
   localparam logic signed [35:0] SAT_LO = -36'sd2147483648;

   typedef struct packed {
      logic signed [31:0] first_x;
      logic signed [31:0] first_y;
      logic signed [31:0] first_vx;
      logic signed [31:0] first_vy;
      logic [30:0]        first_radius;
      logic [30:0]        first_mass;
      logic signed [31:0] second_x;
      logic signed [31:0] second_y;
      logic signed [31:0] second_vx;
      logic signed [31:0] second_vy;
      logic [30:0]        second_radius;
      logic [30:0]        second_mass;
   } req_type;

   typedef struct packed {
      logic               collided;
      logic signed [31:0] new_first_x;
      logic signed [31:0] new_first_y;
      logic signed [31:0] new_first_vx;
      logic signed [31:0] new_first_vy;
      logic signed [31:0] new_second_x;
      logic signed [31:0] new_second_y;
      logic signed [31:0] new_second_vx;
      logic signed [31:0] new_second_vy;
   } rsp_type;

   // per-pair data that rides along the pipeline
   typedef struct packed {
      logic               near;
      logic               hit;
      logic               dist_nz;
      logic               mass_nz;
      logic signed [31:0] x1;
      logic signed [31:0] y1;
      logic signed [31:0] vx1;
      logic signed [31:0] vy1;
      logic signed [31:0] x2;
      logic signed [31:0] y2;
      logic signed [31:0] vx2;
      logic signed [31:0] vy2;
      logic               dx_neg;
      logic               dy_neg;
      logic               dvx_neg;
      logic               dvy_neg;
      logic [31:0]        rs;
      logic [31:0]        ax;
      logic [31:0]        ay;
      logic [31:0]        dvx_mag;
      logic [31:0]        dvy_mag;
      logic [31:0]        m1x2;
      logic [31:0]        m2x2;
      logic [31:0]        msum;
      logic [63:0]        pvx1;
      logic [63:0]        pvy1;
      logic [63:0]        pvx2;
      logic [63:0]        pvy2;
   } side_type;

   function automatic logic [32:0] mag33(input logic signed [32:0] v);
      logic [32:0] r;
      r = v[32] ? 33'(-v) : 33'(v);
      return r;
   endfunction

   // base plus or minus q, clamped to the 32-bit signed range
   function automatic logic signed [31:0] sat_add(input logic signed [31:0] base,
                                                  input logic [QUO_W-1:0] q,
                                                  input logic neg);
      logic signed [35:0] b;
      logic signed [35:0] qs;
      logic signed [35:0] sum;
      logic signed [31:0] r;
      b   = {{4{base[31]}}, base};
      qs  = $signed({{(36-QUO_W){1'b0}}, q});
      if (neg) qs = -qs;
      sum = b + qs;
      if (sum > SAT_HI)      r = SAT_HI[31:0];
      else if (sum < SAT_LO) r = SAT_LO[31:0];
      else                   r = sum[31:0];
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/cpec_div.sv -----
`default_nettype none
module cpec_div import cpec_pkg::*; (
   input  logic             clock,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic [QUO_W-1:0] quotient
);
   // restoring long division, one quotient bit per stage; needs quotient < 2^QUO_W
   logic [DVS_W-1:0] rem_ff [QUO_W];
   logic [QUO_W-1:0] low_ff [QUO_W];
   logic [DVS_W-1:0] dvs_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      logic [DVS_W-1:0] rem_i, dvs_i, rem_in;
      logic [QUO_W-1:0] low_i, quo_i, low_in, quo_in;
      logic [DVS_W:0]   trial;
      logic             ge;
      if (k == 0) begin : g_first
         assign rem_i = DVS_W'(dividend[DVD_W-1:QUO_W]);
         assign low_i = dividend[QUO_W-1:0];
         assign quo_i = '0;
         assign dvs_i = divisor;
      end else begin : g_next
         assign rem_i = rem_ff[k-1];
         assign low_i = low_ff[k-1];
         assign quo_i = quo_ff[k-1];
         assign dvs_i = dvs_ff[k-1];
      end
      always_comb begin
         trial  = {rem_i, low_i[QUO_W-1]};
         ge     = trial >= {1'b0, dvs_i};
         rem_in = ge ? DVS_W'(trial - {1'b0, dvs_i}) : DVS_W'(trial);
         low_in = {low_i[QUO_W-2:0], 1'b0};
         quo_in = {quo_i[QUO_W-2:0], ge};
      end
      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in;
         low_ff[k] <= low_in;
         quo_ff[k] <= quo_in;
         dvs_ff[k] <= dvs_i;
      end
   end

   assign quotient = quo_ff[QUO_W-1];

endmodule
`default_nettype wire

// ----- rtl/circle_pair_elastic_collision.sv -----
`default_nettype none
// elastic collision of two circles, one pair per word, fully pipelined
//
// request channel: a word (req_data) is taken at each rising edge with start
// high and busy low. busy is always low: a new pair can enter every cycle.
// response channel: rsp_strobe is high for exactly one cycle with rsp_data;
// the receiver cannot stall it, and nothing here ever holds a word back.
// depth: the pipeline length is set mostly by the 32-stage square root and the
// 34-stage dividers, each resolving one result bit per stage.
// throughput: one pair per cycle, every stage takes a new word each cycle.
// stages: operand prep, multipliers (32x32), contact test, square root of the
// squared distance, push-out products, six parallel dividers, sign/saturate.
// contact: dx*dx + dy*dy <= (r1 + r2)^2, tested exactly. positions move by
// half the overlap along the center line; coincident centers keep position.
// velocities get the 1D elastic formula per axis; zero total mass keeps them.
// reset: synchronous, clears the valid chain only; words in flight are lost
// and no strobe appears until new pairs are taken.
module circle_pair_elastic_collision import cpec_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);
   // valid chain: prep, mult, test, sqrt stages, products, divider stages
   localparam int VLD_N   = 3 + SQ_N + 1 + QUO_W;
   localparam int SQ_LAST = 2 + SQ_N;
   localparam int LAT     = VLD_N + 1;

   logic [VLD_N-1:0] vld_ff, vld_in;
   logic             rsp_strobe_ff;
   logic             accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign vld_in = {vld_ff[VLD_N-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         vld_ff        <= vld_in;
         rsp_strobe_ff <= vld_ff[VLD_N-1];
      end
   end

   // ---------------- stage 1: differences, magnitudes, sums
   side_type s1_ff, s1_in;
   logic signed [32:0] dx, dy, dvx, dvy;
   logic [32:0] ax_w, ay_w, dvx_w, dvy_w;

   always_comb begin
      dx    = {req_data.second_x[31], req_data.second_x} -
              {req_data.first_x[31], req_data.first_x};
      dy    = {req_data.second_y[31], req_data.second_y} -
              {req_data.first_y[31], req_data.first_y};
      dvx   = {req_data.second_vx[31], req_data.second_vx} -
              {req_data.first_vx[31], req_data.first_vx};
      dvy   = {req_data.second_vy[31], req_data.second_vy} -
              {req_data.first_vy[31], req_data.first_vy};
      ax_w  = mag33(dx);
      ay_w  = mag33(dy);
      dvx_w = mag33(dvx);
      dvy_w = mag33(dvy);
      s1_in         = '0;
      s1_in.rs      = {1'b0, req_data.first_radius} + {1'b0, req_data.second_radius};
      s1_in.msum    = {1'b0, req_data.first_mass} + {1'b0, req_data.second_mass};
      s1_in.mass_nz = (req_data.first_mass != '0) || (req_data.second_mass != '0);
      s1_in.m1x2    = {req_data.first_mass, 1'b0};
      s1_in.m2x2    = {req_data.second_mass, 1'b0};
      // magnitudes beyond the radius sum mean no contact
      s1_in.near    = (ax_w <= {1'b0, s1_in.rs}) && (ay_w <= {1'b0, s1_in.rs});
      s1_in.x1      = req_data.first_x;
      s1_in.y1      = req_data.first_y;
      s1_in.vx1     = req_data.first_vx;
      s1_in.vy1     = req_data.first_vy;
      s1_in.x2      = req_data.second_x;
      s1_in.y2      = req_data.second_y;
      s1_in.vx2     = req_data.second_vx;
      s1_in.vy2     = req_data.second_vy;
      s1_in.dx_neg  = dx[32];
      s1_in.dy_neg  = dy[32];
      s1_in.dvx_neg = dvx[32];
      s1_in.dvy_neg = dvy[32];
      s1_in.ax      = ax_w[31:0];
      s1_in.ay      = ay_w[31:0];
      s1_in.dvx_mag = dvx_w[31:0];
      s1_in.dvy_mag = dvy_w[31:0];
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
   end

   // ---------------- stage 2: squares and momentum products
   side_type    s2_ff, s2_in;
   logic [63:0] sx_ff, sy_ff, rs2_ff, sx_in, sy_in, rs2_in;

   always_comb begin
      sx_in      = s1_ff.ax * s1_ff.ax;
      sy_in      = s1_ff.ay * s1_ff.ay;
      rs2_in     = s1_ff.rs * s1_ff.rs;
      s2_in      = s1_ff;
      s2_in.pvx1 = s1_ff.m2x2 * s1_ff.dvx_mag;
      s2_in.pvy1 = s1_ff.m2x2 * s1_ff.dvy_mag;
      s2_in.pvx2 = s1_ff.m1x2 * s1_ff.dvx_mag;
      s2_in.pvy2 = s1_ff.m1x2 * s1_ff.dvy_mag;
   end

   always_ff @(posedge clock) begin
      s2_ff  <= s2_in;
      sx_ff  <= sx_in;
      sy_ff  <= sy_in;
      rs2_ff <= rs2_in;
   end

   // ---------------- stage 3: exact contact test
   side_type    s3_ff, s3_in;
   logic [63:0] rad_ff, rad_in;
   logic [64:0] sum65;

   always_comb begin
      sum65     = {1'b0, sx_ff} + {1'b0, sy_ff};
      s3_in     = s2_ff;
      s3_in.hit = s2_ff.near && (sum65 <= {1'b0, rs2_ff});
      rad_in    = sum65[63:0];
   end

   always_ff @(posedge clock) begin
      s3_ff  <= s3_in;
      rad_ff <= rad_in;
   end

   // ---------------- square root, one root bit per stage
   logic [63:0] sq_rad_ff  [SQ_N];
   logic [33:0] sq_rem_ff  [SQ_N];
   logic [31:0] sq_root_ff [SQ_N];
   side_type    sq_side_ff [SQ_N];

   for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
      logic [63:0] rad_i, rad_in;
      logic [33:0] rem_i, rem_in;
      logic [31:0] root_i, root_in;
      side_type    side_i;
      logic [35:0] cand, trial;
      if (k == 0) begin : g_first
         assign rad_i  = rad_ff;
         assign rem_i  = '0;
         assign root_i = '0;
         assign side_i = s3_ff;
      end else begin : g_next
         assign rad_i  = sq_rad_ff[k-1];
         assign rem_i  = sq_rem_ff[k-1];
         assign root_i = sq_root_ff[k-1];
         assign side_i = sq_side_ff[k-1];
      end
      always_comb begin
         cand   = {rem_i, rad_i[63:62]};
         trial  = {2'b00, root_i, 2'b01};
         rad_in = {rad_i[61:0], 2'b00};
         if (cand >= trial) begin
            rem_in  = 34'(cand - trial);
            root_in = {root_i[30:0], 1'b1};
         end else begin
            rem_in  = cand[33:0];
            root_in = {root_i[30:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         sq_rad_ff[k]  <= rad_in;
         sq_rem_ff[k]  <= rem_in;
         sq_root_ff[k] <= root_in;
         sq_side_ff[k] <= side_i;
      end
   end

   // ---------------- overlap and push-out products
   side_type    p1_ff, p1_in;
   logic [63:0] px_ff, py_ff, px_in, py_in;
   logic [32:0] den_ff, den_in;
   logic [31:0] ctr_dist, ov;

   always_comb begin
      ctr_dist      = sq_root_ff[SQ_N-1];
      ov            = sq_side_ff[SQ_N-1].rs - ctr_dist;
      px_in         = sq_side_ff[SQ_N-1].ax * ov;
      py_in         = sq_side_ff[SQ_N-1].ay * ov;
      den_in        = {ctr_dist, 1'b0};
      p1_in         = sq_side_ff[SQ_N-1];
      p1_in.dist_nz = (ctr_dist != '0);
   end

   always_ff @(posedge clock) begin
      p1_ff  <= p1_in;
      px_ff  <= px_in;
      py_ff  <= py_in;
      den_ff <= den_in;
   end

   // ---------------- dividers, side data delayed alongside
   logic [QUO_W-1:0] qx, qy, qvx1, qvy1, qvx2, qvy2;
   logic [DVS_W-1:0] msum_dvs;
   side_type         dv_side_ff [QUO_W];

   assign msum_dvs = {1'b0, p1_ff.msum};

   cpec_div u_div_px  (.clock(clock), .dividend(px_ff),      .divisor(den_ff),
                       .quotient(qx));
   cpec_div u_div_py  (.clock(clock), .dividend(py_ff),      .divisor(den_ff),
                       .quotient(qy));
   cpec_div u_div_vx1 (.clock(clock), .dividend(p1_ff.pvx1), .divisor(msum_dvs),
                       .quotient(qvx1));
   cpec_div u_div_vy1 (.clock(clock), .dividend(p1_ff.pvy1), .divisor(msum_dvs),
                       .quotient(qvy1));
   cpec_div u_div_vx2 (.clock(clock), .dividend(p1_ff.pvx2), .divisor(msum_dvs),
                       .quotient(qvx2));
   cpec_div u_div_vy2 (.clock(clock), .dividend(p1_ff.pvy2), .divisor(msum_dvs),
                       .quotient(qvy2));

   for (genvar k = 0; k < QUO_W; k++) begin : g_dly
      side_type side_i;
      if (k == 0) begin : g_first
         assign side_i = p1_ff;
      end else begin : g_next
         assign side_i = dv_side_ff[k-1];
      end
      always_ff @(posedge clock) begin
         dv_side_ff[k] <= side_i;
      end
   end

   // ---------------- apply signs, saturate, register the response word
   side_type fs;
   rsp_type  rsp_ff, rsp_in;
   logic     move_pos, move_vel;

   always_comb begin
      fs       = dv_side_ff[QUO_W-1];
      move_pos = fs.hit && fs.dist_nz;
      move_vel = fs.hit && fs.mass_nz;
      rsp_in.collided      = fs.hit;
      // first circle moves against the center line, second along it
      rsp_in.new_first_x   = move_pos ? sat_add(fs.x1, qx, !fs.dx_neg) : fs.x1;
      rsp_in.new_first_y   = move_pos ? sat_add(fs.y1, qy, !fs.dy_neg) : fs.y1;
      rsp_in.new_second_x  = move_pos ? sat_add(fs.x2, qx, fs.dx_neg) : fs.x2;
      rsp_in.new_second_y  = move_pos ? sat_add(fs.y2, qy, fs.dy_neg) : fs.y2;
      rsp_in.new_first_vx  = move_vel ? sat_add(fs.vx1, qvx1, fs.dvx_neg) : fs.vx1;
      rsp_in.new_first_vy  = move_vel ? sat_add(fs.vy1, qvy1, fs.dvy_neg) : fs.vy1;
      rsp_in.new_second_vx = move_vel ? sat_add(fs.vx2, qvx2, !fs.dvx_neg) : fs.vx2;
      rsp_in.new_second_vy = move_vel ? sat_add(fs.vy2, qvy2, !fs.dvy_neg) : fs.vy2;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // ---------------- assertions
   a_strobe_follows_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LAT))
      else $error("response word without a matching request");

   a_root_within_radius: assert property (@(posedge clock) disable iff (reset)
      vld_ff[SQ_LAST] && sq_side_ff[SQ_N-1].hit |->
         sq_root_ff[SQ_N-1] <= sq_side_ff[SQ_N-1].rs)
      else $error("center distance exceeds radius sum on a contact");

   a_miss_passes_position: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.collided |->
         rsp_data.new_first_x == $past(req_data.first_x, LAT) &&
         rsp_data.new_second_y == $past(req_data.second_y, LAT))
      else $error("position changed without contact");

   a_miss_passes_velocity: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.collided |->
         rsp_data.new_first_vx == $past(req_data.first_vx, LAT) &&
         rsp_data.new_second_vy == $past(req_data.second_vy, LAT))
      else $error("velocity changed without contact");

endmodule
`default_nettype wire
